// ===== sv/mmcd_pkg.sv =====
// Shared types and constants for the min/max column decimator.
package mmcd_pkg;

  localparam int unsigned MAX_GROUP_DEF = 4096;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GSIZE_W  = 13;
  localparam int unsigned SCALE_W  = 32;

  localparam logic [GSIZE_W-1:0] GSIZE_RESET = 13'd1;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

  // register index, taken from paddr[2]
  localparam logic REG_GROUP_SIZE  = 1'b0;
  localparam logic REG_PIXEL_SCALE = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                is_last;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] inv_max;
    logic [SAMPLE_W-1:0] inv_min;
    logic [SAMPLE_W-1:0] pix_top;
    logic [SAMPLE_W-1:0] pix_bottom;
    logic                last_column;
  } out_t;

  // closed column, before pixel scaling
  typedef struct packed {
    logic [SAMPLE_W-1:0] inv_max;
    logic [SAMPLE_W-1:0] inv_min;
    logic                last_column;
  } col_t;

endpackage

// ===== sv/mmcd_regs.sv =====
// APB configuration registers: group size and pixel scale.
module mmcd_regs
  import mmcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [GSIZE_W-1:0] group_size,
  output logic [SCALE_W-1:0] pixel_scale
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size  <= GSIZE_RESET;
      pixel_scale <= SCALE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_GROUP_SIZE:  group_size  <= pwdata[GSIZE_W-1:0];
        REG_PIXEL_SCALE: pixel_scale <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_GROUP_SIZE:  prdata = {{(32-GSIZE_W){1'b0}}, group_size};
      REG_PIXEL_SCALE: prdata = pixel_scale;
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== sv/mmcd_accum.sv =====
// Column tracker: running min/max, group counting, closed-column register.
module mmcd_accum
  import mmcd_pkg::*;
#(
  parameter int unsigned MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,        // input item accepted
  input  in_t                in_data,
  input  logic [GSIZE_W-1:0] group_size,
  input  logic               col_adv,     // column register may load
  output logic               col_valid,
  output col_t               col
);

  localparam int unsigned CNT_W = $clog2(MAX_GROUP + 1);
  localparam int unsigned CMP_W = (CNT_W > GSIZE_W) ? CNT_W : GSIZE_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_GROUP);

  logic [CNT_W-1:0]    count;
  logic [SAMPLE_W-1:0] run_max;
  logic [SAMPLE_W-1:0] run_min;

  logic [CNT_W-1:0]    count_next;
  logic [SAMPLE_W-1:0] max_next;
  logic [SAMPLE_W-1:0] min_next;
  logic [CMP_W-1:0]    gsize_ext;
  logic [CMP_W-1:0]    eff_size;
  logic                close;

  always_comb begin
    gsize_ext = CMP_W'(group_size);
    if (gsize_ext == '0) begin
      eff_size = CMP_W'(1);
    end else if (gsize_ext > MAX_CMP) begin
      eff_size = MAX_CMP;
    end else begin
      eff_size = gsize_ext;
    end

    count_next = count + CNT_W'(1);
    if (count == '0) begin
      max_next = in_data.sample;
      min_next = in_data.sample;
    end else begin
      max_next = (in_data.sample > run_max) ? in_data.sample : run_max;
      min_next = (in_data.sample < run_min) ? in_data.sample : run_min;
    end
    close = in_data.is_last || (CMP_W'(count_next) >= eff_size);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      run_max <= '0;
      run_min <= '0;
    end else if (take) begin
      count   <= close ? '0 : count_next;
      run_max <= max_next;
      run_min <= min_next;
    end
  end

  // closed-column register
  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= 1'b0;
    end else if (col_adv) begin
      col_valid <= take & close;
    end
  end

  always_ff @(posedge clk) begin
    if (col_adv && take && close) begin
      col.inv_max     <= ~max_next;
      col.inv_min     <= ~min_next;
      col.last_column <= in_data.is_last;
    end
  end

endmodule

// ===== sv/mmcd_scale.sv =====
// Pixel scaling of a closed column and the output register.
module mmcd_scale
  import mmcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               col_valid,
  input  col_t               col,
  input  logic [SCALE_W-1:0] pixel_scale,
  output logic               adv,
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data
);

  localparam int unsigned PROD_W = SAMPLE_W + SCALE_W;

  logic [PROD_W-1:0] prod_top;
  logic [PROD_W-1:0] prod_bot;

  assign adv = ~out_valid | ~out_stall;

  assign prod_top = PROD_W'(col.inv_max) * PROD_W'(pixel_scale);
  assign prod_bot = PROD_W'(col.inv_min) * PROD_W'(pixel_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= col_valid;
    end
  end

  // bits 31:16 of the product: wrap modulo 2^32, then drop the fraction
  always_ff @(posedge clk) begin
    if (adv && col_valid) begin
      out_data.inv_max     <= col.inv_max;
      out_data.inv_min     <= col.inv_min;
      out_data.pix_top     <= prod_top[31:16];
      out_data.pix_bottom  <= prod_bot[31:16];
      out_data.last_column <= col.last_column;
    end
  end

endmodule

// ===== sv/minmax_column_decimator_top.sv =====
// Top level of the min/max column decimator.
//
//  channel   dir  handshake               payload
//  in        in   in_valid / in_stall     in_data  (sample, is_last)
//  out       out  out_valid / out_stall   out_data (inv_max, inv_min, pix_top,
//                                                   pix_bottom, last_column)
//  config    in   APB psel/penable/pwrite paddr[2:0], pwdata, prdata
//
// One sample can be taken every cycle while in_stall is low. A closing sample is
// loaded into the column register at its accepting edge, after the min/max
// compare and count, and then reaches out_data through the two 16x32 multipliers
// into the output register. rst is synchronous: the open column is dropped,
// group_size returns to 1 and pixel_scale to 1.0 (0x10000). A stalled output
// holds; the column register takes one more closed column behind it, and
// in_stall is high while both registers hold a column and out_stall is high,
// for every sample, whether or not it would close a column.
module minmax_column_decimator_top
  import mmcd_pkg::*;
#(
  parameter int unsigned MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // sample stream
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  // column stream
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [GSIZE_W-1:0] group_size;
  logic [SCALE_W-1:0] pixel_scale;
  logic               col_valid;
  col_t               col;
  logic               adv_out;   // output register can load
  logic               adv_col;   // column register can load
  logic               take;

  // column register frees up when empty or when it drains into the output
  assign adv_col  = ~col_valid | adv_out;
  assign in_stall = ~adv_col;
  assign take     = in_valid & ~in_stall;

  mmcd_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .group_size  (group_size),
    .pixel_scale (pixel_scale)
  );

  mmcd_accum #(
    .MAX_GROUP (MAX_GROUP)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .in_data    (in_data),
    .group_size (group_size),
    .col_adv    (adv_col),
    .col_valid  (col_valid),
    .col        (col)
  );

  mmcd_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .col_valid   (col_valid),
    .col         (col),
    .pixel_scale (pixel_scale),
    .adv         (adv_out),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
